// File: design/gravity_tilt_angle_checker_core_assert.svh
// Assertion macros for the gravity tilt angle checker.
`ifndef GRAVITY_TILT_ANGLE_CHECKER_CORE_ASSERT_SVH
`define GRAVITY_TILT_ANGLE_CHECKER_CORE_ASSERT_SVH
// Implication checked every clock edge outside reset.
`define GTAC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("gtac assertion failed");
// Implication whose consequent is checked in the cycle after its antecedent.
`define GTAC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("gtac assertion failed");
`endif

// File: design/gtac_pkg.sv
// Package: types, constants and the CORDIC angle table of the tilt checker.
package gtac_pkg;
    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int COUNTER_WIDTH_DEF     = 16;
    localparam int ANG_TABLE_LEN         = 24;
    localparam int ACC_W                 = 25;
    localparam int CW                    = 26;
    localparam int MAG_W                 = 34;

    localparam logic [1:0] ST_VALID  = 2'd0;
    localparam logic [1:0] ST_WINDOW = 2'd1;
    localparam logic [1:0] ST_FAILED = 2'd2;

    localparam logic [1:0] REG_WIN_LOW  = 2'd0;
    localparam logic [1:0] REG_WIN_HIGH = 2'd1;
    localparam logic [1:0] REG_FLIP     = 2'd2;
    localparam logic [1:0] REG_MAX_ATT  = 2'd3;

    typedef struct packed {
        logic signed [15:0] grav_x;
        logic signed [15:0] grav_y;
        logic signed [15:0] grav_z;
        logic               read_failed;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic               read_done;
        logic               limit_hit;
        logic [15:0]        limit_errors;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  index;
        logic [11:0] data;
    } t_cfg_write;

    function automatic logic signed [ACC_W-1:0] atan_q8(input logic [4:0] i);
        logic signed [ACC_W-1:0] v;
        unique case (i)
            5'd0:  v = 25'sd1152000;
            5'd1:  v = 25'sd680065;
            5'd2:  v = 25'sd359328;
            5'd3:  v = 25'sd182400;
            5'd4:  v = 25'sd91554;
            5'd5:  v = 25'sd45822;
            5'd6:  v = 25'sd22916;
            5'd7:  v = 25'sd11459;
            5'd8:  v = 25'sd5730;
            5'd9:  v = 25'sd2865;
            5'd10: v = 25'sd1432;
            5'd11: v = 25'sd716;
            5'd12: v = 25'sd358;
            5'd13: v = 25'sd179;
            5'd14: v = 25'sd90;
            5'd15: v = 25'sd45;
            5'd16: v = 25'sd22;
            5'd17: v = 25'sd11;
            5'd18: v = 25'sd6;
            5'd19: v = 25'sd3;
            5'd20: v = 25'sd1;
            5'd21: v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

// File: design/gtac_cordic.sv
// Vectoring CORDIC atan2 unit, one iteration per cycle.
module gtac_cordic #(
    parameter int ITERS = gtac_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [15:0]  i_num,
    input  logic signed [15:0]  i_den,
    output logic                o_done,
    output logic signed [15:0]  o_angle
);
    import gtac_pkg::*;

    localparam int N = (ITERS > ANG_TABLE_LEN) ? ANG_TABLE_LEN : ITERS;

    logic                    r_busy, n_busy;
    logic [4:0]              r_i, n_i;
    logic signed [CW-1:0]    r_x, n_x, r_y, n_y;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic                    r_done, n_done;
    logic signed [15:0]      r_ang, n_ang;
    logic signed [CW-1:0]    x0, y0, dx, dy;
    logic signed [ACC_W-1:0] rnd;

    always_comb begin
        n_busy = r_busy;
        n_i    = r_i;
        n_x    = r_x;
        n_y    = r_y;
        n_acc  = r_acc;
        n_done = 1'b0;
        n_ang  = r_ang;
        x0 = CW'(i_den) <<< 8;
        y0 = CW'(i_num) <<< 8;
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        rnd = (r_acc + ACC_W'(128)) >>> 8;
        if (i_start) begin
            n_i = '0;
            if (i_num == 0 && i_den == 0) begin
                n_done = 1'b1;
                n_ang  = '0;
            end else begin
                n_busy = 1'b1;
                if (i_den < 0) begin
                    n_x   = -x0;
                    n_y   = -y0;
                    n_acc = (i_num >= 0) ? 25'sd4608000 : -25'sd4608000;
                end else begin
                    n_x   = x0;
                    n_y   = y0;
                    n_acc = '0;
                end
            end
        end else if (r_busy) begin
            if (r_i == 5'(N)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (rnd > 25'sd18000) n_ang = 16'sd18000;
                else if (rnd < -25'sd18000) n_ang = -16'sd18000;
                else n_ang = 16'(rnd);
            end else begin
                n_i = r_i + 5'd1;
                if (r_y >= 0) begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_acc = r_acc + atan_q8(r_i);
                end else begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_acc = r_acc - atan_q8(r_i);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_i   <= n_i;
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
        r_ang <= n_ang;
    end

    assign o_done  = r_done;
    assign o_angle = r_ang;
endmodule

// File: design/gravity_tilt_angle_checker_core.sv
// Top level: gravity tilt angle checker with magnitude window and read tracking.
// A failed read skips the magnitude check; a sample outside the window is rejected after the
// bit-serial squared magnitude, and an accepted one then runs the CORDIC for roll and pitch.
// Throughput: one item at a time; the shared CORDIC unit and serial squarer set it.
// The next item may be taken while the result still waits in the output register.
// Reset (i_rst_n low, synchronous) restores the register defaults and clears counters.
module gravity_tilt_angle_checker_core #(
    parameter int CORDIC_ITERATIONS = gtac_pkg::CORDIC_ITERATIONS_DEF,
    parameter int COUNTER_WIDTH     = gtac_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  gtac_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output gtac_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  gtac_pkg::t_cfg_write i_cfg_data
);
    import gtac_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MAG   = 6'b000010,
        S_ROLL  = 6'b000100,
        S_PITCH = 6'b001000,
        S_FIN   = 6'b010000,
        S_HOLD  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [11:0] r_win_lo, r_win_hi;
    logic        r_flip;
    logic [5:0]  r_max_att;

    // read tracking
    logic [5:0]               r_att;
    logic [COUNTER_WIDTH-1:0] r_errs;

    // captured sample
    t_in_item r_item;

    // serial squarer: one multiplier bit per cycle over 16 bits of |x|,|y|,|z|
    logic [15:0]      r_ax, r_ay, r_az;   // shifting multiplier bits
    logic [15:0]      r_mx, r_my, r_mz;   // multiplicands
    logic [MAG_W-1:0] r_mag;
    logic [4:0]       r_bit;

    // outputs
    logic      r_out_valid;
    t_out_item r_out;
    logic [1:0]         r_status;
    logic signed [15:0] r_roll;

    // cordic
    logic               c_start;
    logic signed [15:0] c_num, c_den;
    logic               c_done;
    logic signed [15:0] c_ang;

    logic [15:0] abs_x, abs_y, abs_z;
    logic [23:0] lo2, hi2;
    logic [5:0]  cnt, lim;
    logic        done_f, hit_f;
    logic [MAG_W-1:0] part;

    gtac_cordic #(.ITERS(CORDIC_ITERATIONS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_num   (c_num),
        .i_den   (c_den),
        .o_done  (c_done),
        .o_angle (c_ang)
    );

    assign o_cfg_ready = 1'b1;
    // a result parked in r_out does not block the next sample; S_FIN waits for it
    assign o_in_ready  = (r_state == S_IDLE) || (r_state == S_HOLD);

    always_comb begin
        abs_x = i_in_data.grav_x[15] ? 16'(-i_in_data.grav_x) : i_in_data.grav_x;
        abs_y = i_in_data.grav_y[15] ? 16'(-i_in_data.grav_y) : i_in_data.grav_y;
        abs_z = i_in_data.grav_z[15] ? 16'(-i_in_data.grav_z) : i_in_data.grav_z;
        // window squares: 12x12 multiplies, small
        lo2 = 24'(r_win_lo) * 24'(r_win_lo);
        hi2 = 24'(r_win_hi) * 24'(r_win_hi);
        part = (r_ax[0] ? (MAG_W'(r_mx) << r_bit) : '0)
             + (r_ay[0] ? (MAG_W'(r_my) << r_bit) : '0)
             + (r_az[0] ? (MAG_W'(r_mz) << r_bit) : '0);
        cnt = r_att + 6'd1;
        lim = (r_max_att == 6'd0) ? 6'd1 : r_max_att;
        done_f = (r_status == ST_VALID) || (cnt >= lim);
        hit_f  = (cnt >= lim) && (cnt > 6'd1);
        c_start = 1'b0;
        c_num = r_item.grav_y;
        c_den = r_item.grav_z;
        n_state = r_state;
        unique case (r_state)
            S_IDLE, S_HOLD: begin
                if (i_in_valid && o_in_ready) n_state = S_MAG;
            end
            S_MAG: begin
                if (r_item.read_failed) n_state = S_FIN;
                else if (r_bit == 5'd16) begin
                    if (r_mag > MAG_W'(lo2) && r_mag < MAG_W'(hi2)) begin
                        n_state = S_ROLL;
                        c_start = 1'b1;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_ROLL: begin
                if (c_done) begin
                    n_state = S_PITCH;
                    c_start = 1'b1;
                    c_num = r_item.grav_x;
                end
            end
            S_PITCH: if (c_done) n_state = S_FIN;
            S_FIN:   if (!r_out_valid) n_state = S_HOLD;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win_lo    <= 12'd970;
            r_win_hi    <= 12'd990;
            r_flip      <= 1'b1;
            r_max_att   <= 6'd20;
            r_att       <= '0;
            r_errs      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_data.index)
                    REG_WIN_LOW:  r_win_lo  <= i_cfg_data.data;
                    REG_WIN_HIGH: r_win_hi  <= i_cfg_data.data;
                    REG_FLIP:     r_flip    <= i_cfg_data.data[0];
                    REG_MAX_ATT:  r_max_att <= i_cfg_data.data[5:0];
                endcase
            end
            if (o_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (r_state == S_FIN && !r_out_valid) begin
                r_out_valid <= 1'b1;
                r_att <= done_f ? 6'd0 : cnt;
                if (hit_f && r_errs != {COUNTER_WIDTH{1'b1}}) r_errs <= r_errs + 1'b1;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item   <= i_in_data;
            r_ax <= abs_x; r_ay <= abs_y; r_az <= abs_z;
            r_mx <= abs_x; r_my <= abs_y; r_mz <= abs_z;
            r_mag    <= '0;
            r_bit    <= '0;
            r_status <= i_in_data.read_failed ? ST_FAILED : ST_WINDOW;
            r_roll   <= '0;
        end else if (r_state == S_MAG && r_bit != 5'd16) begin
            r_mag <= r_mag + part;
            r_ax <= r_ax >> 1; r_ay <= r_ay >> 1; r_az <= r_az >> 1;
            r_bit <= r_bit + 5'd1;
        end
        if (r_state == S_ROLL && c_done) begin
            r_roll   <= r_flip ? 16'(-c_ang) : c_ang;
            r_status <= ST_VALID;
        end
        if (r_state == S_FIN && !r_out_valid) begin
            r_out.status      <= r_status;
            r_out.roll_angle  <= (r_status == ST_VALID) ? r_roll : 16'sd0;
            r_out.pitch_angle <= (r_status == ST_VALID) ? c_ang : 16'sd0;
            r_out.read_done   <= done_f;
            r_out.limit_hit   <= hit_f;
            if (COUNTER_WIDTH > 16) begin
                r_out.limit_errors <= 16'hFFFF;
                if ((hit_f && r_errs != {COUNTER_WIDTH{1'b1}} ? r_errs + 1'b1 : r_errs)
                    <= COUNTER_WIDTH'(16'hFFFF))
                    r_out.limit_errors <= 16'(hit_f && r_errs != {COUNTER_WIDTH{1'b1}}
                                              ? r_errs + 1'b1 : r_errs);
            end else begin
                r_out.limit_errors <= 16'(hit_f && r_errs != {COUNTER_WIDTH{1'b1}}
                                          ? r_errs + 1'b1 : r_errs);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

// File: design/gtac_checker.sv
// Port-level checker for the tilt checker, bound to the top level.
`include "gravity_tilt_angle_checker_core_assert.svh"
module gtac_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input gtac_pkg::t_out_item o_out_data
);
    import gtac_pkg::*;
    `GTAC_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    `GTAC_ASSERT_IMP(a_zero, i_clk, i_rst_n, o_out_valid && o_out_data.status != ST_VALID, o_out_data.roll_angle == 0 && o_out_data.pitch_angle == 0)
    `GTAC_ASSERT_IMP(a_hit, i_clk, i_rst_n, o_out_valid && o_out_data.limit_hit, o_out_data.read_done && o_out_data.limit_errors != 0)
    `GTAC_ASSERT_IMP(a_valid_done, i_clk, i_rst_n, o_out_valid && o_out_data.status == ST_VALID, o_out_data.read_done)
endmodule

bind gravity_tilt_angle_checker_core gtac_checker u_gtac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: tb/sv/gravity_tilt_angle_checker_core_scoreboard.sv
// Checker for the tilt angle core: predicts each result and compares it.
`timescale 1ns / 1ps

module gravity_tilt_angle_checker_core_scoreboard #(
    parameter int CORDIC_ITERATIONS = gtac_pkg::CORDIC_ITERATIONS_DEF,
    parameter int COUNTER_WIDTH     = gtac_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  gtac_pkg::t_in_item   i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  gtac_pkg::t_out_item  i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  gtac_pkg::t_cfg_write i_cfg_data,
    output int                   o_pending,
    output int                   o_fail_count
);
    import gtac_pkg::*;

    localparam longint HALF_TURN = 4608000;
    localparam longint LIMIT_CDEG = 18000;

    // atan(2^-i) in 1/256 of 0.01 degree
    longint arc_step [24] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916,
                              11459, 5730, 2865, 1432, 716, 358, 179, 90, 45,
                              22, 11, 6, 3, 1, 1, 0, 0};

    logic [11:0]  win_lo;
    logic [11:0]  win_hi;
    logic         roll_neg;
    logic [5:0]   attempt_max;
    logic [5:0]   attempts;
    longint       limit_errs;
    t_out_item    expected_results[$];
    int           fails;

    assign o_pending    = expected_results.size();
    assign o_fail_count = fails;

    function automatic longint tilt_angle(longint num, longint den);
        longint xv, yv, acc, dx, dy, res;
        int     steps;
        if (num == 0 && den == 0) return 0;
        xv = den * 256;
        yv = num * 256;
        acc = 0;
        if (den < 0) begin
            xv = -xv;
            yv = -yv;
            acc = (num >= 0) ? HALF_TURN : -HALF_TURN;
        end
        steps = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
        for (int i = 0; i < steps; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0) begin
                xv += dx;
                yv -= dy;
                acc += arc_step[i];
            end else begin
                xv -= dx;
                yv += dy;
                acc -= arc_step[i];
            end
        end
        res = (acc + 128) >>> 8;
        if (res > LIMIT_CDEG) res = LIMIT_CDEG;
        if (res < -LIMIT_CDEG) res = -LIMIT_CDEG;
        return res;
    endfunction

    function automatic t_out_item tilt_result(t_in_item s);
        t_out_item r;
        longint    gx, gy, gz, mag2, roll;
        int        cnt, lim;
        logic      done, hit;
        longint    cmax;
        cmax = (longint'(1) << COUNTER_WIDTH) - 1;
        r = '0;
        gx = s.grav_x;
        gy = s.grav_y;
        gz = s.grav_z;
        if (s.read_failed) begin
            r.status = ST_FAILED;
        end else begin
            mag2 = gx * gx + gy * gy + gz * gz;
            if (mag2 > longint'(win_lo) * win_lo && mag2 < longint'(win_hi) * win_hi) begin
                r.status = ST_VALID;
                roll = tilt_angle(gy, gz);
                if (roll_neg) roll = -roll;
                r.roll_angle  = roll[15:0];
                r.pitch_angle = 16'(tilt_angle(gx, gz));
            end else begin
                r.status = ST_WINDOW;
            end
        end
        cnt  = attempts + 1;
        lim  = (attempt_max == 0) ? 1 : attempt_max;
        done = (r.status == ST_VALID) || (cnt >= lim);
        hit  = (cnt >= lim) && (cnt > 1);
        if (hit && limit_errs < cmax) limit_errs++;
        attempts = done ? 6'd0 : 6'(cnt);
        r.read_done    = done;
        r.limit_hit    = hit;
        r.limit_errors = (limit_errs > 65535) ? 16'hFFFF : 16'(limit_errs);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            win_lo      <= 12'd970;
            win_hi      <= 12'd990;
            roll_neg    <= 1'b1;
            attempt_max <= 6'd20;
            attempts    = 6'd0;
            limit_errs  = 0;
            expected_results.delete();
            fails       <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data.index)
                    REG_WIN_LOW:  win_lo      <= i_cfg_data.data;
                    REG_WIN_HIGH: win_hi      <= i_cfg_data.data;
                    REG_FLIP:     roll_neg    <= i_cfg_data.data[0];
                    REG_MAX_ATT:  attempt_max <= i_cfg_data.data[5:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(tilt_result(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fails <= fails + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== i_out_data) fails <= fails + 1;
                    if (exp_r.status !== i_out_data.status)
                        $error("status exp %0d got %0d", exp_r.status, i_out_data.status);
                    if (exp_r.roll_angle !== i_out_data.roll_angle)
                        $error("roll_angle exp %0d got %0d",
                               exp_r.roll_angle, i_out_data.roll_angle);
                    if (exp_r.pitch_angle !== i_out_data.pitch_angle)
                        $error("pitch_angle exp %0d got %0d",
                               exp_r.pitch_angle, i_out_data.pitch_angle);
                    if (exp_r.read_done !== i_out_data.read_done)
                        $error("read_done exp %0d got %0d",
                               exp_r.read_done, i_out_data.read_done);
                    if (exp_r.limit_hit !== i_out_data.limit_hit)
                        $error("limit_hit exp %0d got %0d",
                               exp_r.limit_hit, i_out_data.limit_hit);
                    if (exp_r.limit_errors !== i_out_data.limit_errors)
                        $error("limit_errors exp %0d got %0d",
                               exp_r.limit_errors, i_out_data.limit_errors);
                end
            end
        end
    end
endmodule

// File: tb/sv/gravity_tilt_angle_checker_core_test.sv
// Testbench top for the tilt angle core: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module gravity_tilt_angle_checker_core_test;
    import gtac_pkg::*;

    localparam int STALL_LIMIT = 20000;  // cycles with no transfer at all
    localparam int SETTLE      = 100;    // margin beyond the worst-case latency

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_item   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    t_cfg_write cfg_data = '0;
    int         pending;
    int         fail_count;
    int         ready_mode = 0;   // receiver stall pattern, changed per phase
    int         ready_tick = 0;
    int         quiet_cycles = 0;
    int         burst_left = 0;
    int         lo_now = 970;
    int         hi_now = 990;

    always #5 i_clk = ~i_clk;

    gravity_tilt_angle_checker_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    gravity_tilt_angle_checker_core_scoreboard tilt_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Receiver side: free running, random, periodic or long-stall patterns.
    always @(posedge i_clk) begin
        ready_tick <= ready_tick + 1;
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(1, 0));
            2: out_ready <= (ready_tick % 7) >= 3;
            default: out_ready <= (ready_tick % 64) < 8;
        endcase
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[gravity_tilt_angle_checker_core] ERROR");
            $finish;
        end
    end

    // One register write; only issued while the core is drained.
    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_data  <= '{index: idx, data: val};
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_WIN_LOW) lo_now = val;
        if (idx == REG_WIN_HIGH) hi_now = val;
    endtask

    // Sample transfer; bursts keep valid high across back to back items.
    task automatic send_sample(t_in_item s);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(8, 1);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(30, 1);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do @(posedge i_clk); while (!in_ready);
        burst_left--;
    endtask

    task automatic send_vec(int gx, int gy, int gz, bit failed = 0);
        send_sample('{grav_x: 16'(gx), grav_y: 16'(gy), grav_z: 16'(gz),
                      read_failed: failed});
    endtask

    // Lower valid, wait for every expected result, then let the core settle.
    task automatic drain;
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Mostly vectors sized inside the current window, plus failed reads and noise.
    function automatic t_in_item pick_sample();
        t_in_item s;
        real      m, a, b, rest;
        int       c, pick;
        s = 49'({$urandom, $urandom});
        pick = $urandom_range(99, 0);
        if (pick < 15) begin
            s.read_failed = 1'b1;
        end else if (pick >= 30) begin
            s.read_failed = 1'b0;
            m = ($urandom_range(1000, 0) / 1000.0) * (hi_now - lo_now) + lo_now;
            a = (($urandom_range(2000, 0) / 1000.0) - 1.0) * m * 0.7;
            b = (($urandom_range(2000, 0) / 1000.0) - 1.0) * m * 0.7;
            rest = m * m - a * a - b * b;
            c = (rest > 0.0) ? int'($sqrt(rest)) : 0;
            if ($urandom_range(1, 0)) c = -c;
            case ($urandom_range(2, 0))
                0: begin s.grav_x = 16'(c); s.grav_y = 16'(int'(a)); s.grav_z = 16'(int'(b)); end
                1: begin s.grav_y = 16'(c); s.grav_x = 16'(int'(a)); s.grav_z = 16'(int'(b)); end
                default: begin
                    s.grav_z = 16'(c); s.grav_x = 16'(int'(a)); s.grav_y = 16'(int'(b));
                end
            endcase
        end
        return s;
    endfunction

    initial begin
        int lo, hi;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset window 970..990, roll flipped, 20 attempts per read.
        send_vec(0, 0, 980);
        send_vec(0, 980, 0);
        send_vec(980, 0, 0);              // roll sees a zero vector pair
        send_vec(0, 0, -980);             // negative denominator, numerator zero
        send_vec(-500, -500, -700);       // negative denominator and numerator, but outside the window
        send_vec(400, -600, 600);
        send_vec(32767, 32767, 32767);
        send_vec(-32768, -32768, -32768);
        send_vec(0, 0, 0);
        send_vec(-32768, 32767, 0, 1);
        send_vec(0, 0, 970);              // on the lower bound: rejected
        send_vec(0, 0, 990);              // on the upper bound: rejected
        repeat (20) send_vec(0, 0, 0, 1); // read hits the attempt limit
        drain();

        // Limit lowered to three and roll flip cleared; the last two samples fall outside the window.
        write_reg(REG_MAX_ATT, 12'hFC3);  // upper bits ignored, limit 3
        write_reg(REG_FLIP, 12'hFFE);     // bit 0 clear
        send_vec(1, 1, 1, 1);
        send_vec(5, 5, 5);
        send_vec(-600, 700, -300);
        drain();

        // Limit lowered mid-read.
        write_reg(REG_MAX_ATT, 12'd30);
        repeat (10) send_vec(0, 0, 0, 1);
        drain();
        write_reg(REG_MAX_ATT, 12'd5);
        send_vec(0, 0, 0, 1);
        send_vec(0, 0, 980);
        drain();

        // Limit of one and of zero: reads end at once, never flagged.
        write_reg(REG_MAX_ATT, 12'd1);
        send_vec(0, 0, 0, 1);
        send_vec(7, 7, 7);
        drain();
        write_reg(REG_MAX_ATT, 12'd0);
        send_vec(0, 0, 0, 1);
        drain();

        // Crossed and equal window bounds; then the widest window.
        write_reg(REG_WIN_LOW, 12'd990);
        write_reg(REG_WIN_HIGH, 12'd970);
        send_vec(0, 0, 980);
        drain();
        write_reg(REG_WIN_HIGH, 12'd990);
        send_vec(0, 0, 990);
        drain();
        write_reg(REG_WIN_LOW, 12'd0);
        write_reg(REG_WIN_HIGH, 12'hFFF);
        write_reg(REG_MAX_ATT, 12'd63);
        send_vec(0, 0, 1);
        send_vec(-4000, 0, -1);
        drain();

        // Random phases, each with its own settings and receiver pattern.
        for (int ph = 0; ph < 9; ph++) begin
            case (ph % 3)
                0: begin lo = $urandom_range(3000, 50); hi = lo + $urandom_range(600, 20); end
                1: begin lo = $urandom_range(40, 0); hi = $urandom_range(4095, 3500); end
                default: begin lo = $urandom_range(2000, 500); hi = lo + 2; end
            endcase
            write_reg(REG_WIN_LOW, 12'(lo));
            write_reg(REG_WIN_HIGH, 12'(hi));
            write_reg(REG_FLIP, 12'($urandom));
            write_reg(REG_MAX_ATT, (ph == 4) ? 12'd63 : 12'($urandom_range(8, 1)));
            ready_mode = ph % 4;
            repeat (80) send_sample(pick_sample());
            drain();
        end

        ready_mode = 0;
        drain();
        if (fail_count == 0)
            $display("[gravity_tilt_angle_checker_core] OK");
        else
            $display("[gravity_tilt_angle_checker_core] ERROR");
        $finish;
    end
endmodule
